FILE: hw/rtl/ole_pkg.sv
// Shared types and codes for the ordered list engine.
// Used by the list cell and the top level; depends on nothing else.
package ole_pkg;

  localparam int ValueWidth = 32;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  // Flags that ripple down the row from the newest cell toward the oldest.
  typedef struct packed {
    logic any_le;
    logic any_eq;
  } ole_chain_t;

  // Per-operation command broadcast to every cell.
  typedef struct packed {
    logic add;      // push or ordered insert that fits
    logic ordered;  // add goes to the ordered position rather than the newest end
    logic remove;   // delete with a match somewhere in the list
  } ole_cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic       valid;
    logic       le;
    ole_chain_t chain;
  } ole_below_t;

endpackage

FILE: hw/rtl/ordered_list_engine.sv
// Ordered list engine: a bounded list of signed words kept in a row of cells.
// Channels: an input word (opcode, operand_value) on item_valid / item_stall, and
// a result word (found, status, occupancy) on result_valid / result_stall. A word
// moves at a clock edge where valid is high and stall is low.
// Opcodes: push at the newest end, ordered insert, delete newest match, search.
// Every cell compares its entry with the key at once; "any match above" and
// "any entry not greater above" flags ripple down the row, and every cell then
// loads its own key, its lower or its upper neighbor in the same cycle.
// An accepted word waits in the operation register; its result is then held in the
// result register. Throughput: one word per cycle while no stalled result is held;
// the operation updates the list in the cycle it leaves the operation register, so
// the next word sees the new contents.
// The critical path is the flag ripple through LIST_DEPTH cells.
// When result_stall holds a result, the operation register waits and item_stall
// rises; nothing is lost or repeated.
// Reset empties the list (all valid flags and the count cleared) and drops any
// word in flight; entry values themselves are not cleared.
// Occupancy reports the count modulo 32 when the list is deeper than 31.
module ordered_list_engine #(
  parameter int LIST_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  opcode,
  input  logic signed [31:0] operand_value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        found,
  output logic [1:0]  status,
  output logic [4:0]  occupancy
);
  import ole_pkg::*;

  localparam int CountWidth = $clog2(LIST_DEPTH + 1);

  logic                  op_valid;
  logic [1:0]            op_code;
  logic signed [31:0]    op_key;
  logic                  exec;
  logic [CountWidth-1:0] count;
  logic [CountWidth-1:0] count_next;
  logic                  full;
  logic                  hit;
  logic                  is_add;
  ole_cmd_t              cmd;
  logic                  found_next;
  logic [1:0]            status_next;

  ole_below_t            info   [LIST_DEPTH];
  logic signed [31:0]    values [LIST_DEPTH];

  assign exec       = op_valid && (!result_valid || !result_stall);
  assign item_stall = op_valid && !exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (!item_stall) begin
      op_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      op_code <= opcode;
      op_key  <= operand_value;
    end
  end

  assign full   = (count == CountWidth'(LIST_DEPTH));
  assign hit    = info[0].chain.any_eq;
  assign is_add = (op_code == OP_PUSH) || (op_code == OP_INSERT);

  assign cmd.add     = is_add && !full;
  assign cmd.ordered = (op_code == OP_INSERT);
  assign cmd.remove  = (op_code == OP_DELETE) && hit;

  genvar gi;
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      ole_below_t         lower;
      logic signed [31:0] lower_value;
      logic               upper_valid;
      logic signed [31:0] upper_value;
      ole_chain_t         chain_in;

      if (gi == 0) begin : g_oldest
        // A virtual entry below the oldest cell: present and never greater than the key.
        assign lower.valid        = 1'b1;
        assign lower.le           = 1'b1;
        assign lower.chain.any_le = 1'b1;
        assign lower.chain.any_eq = 1'b0;
        assign lower_value        = op_key;
      end else begin : g_inner_low
        assign lower       = info[gi-1];
        assign lower_value = values[gi-1];
      end

      if (gi == LIST_DEPTH - 1) begin : g_newest
        assign upper_valid     = 1'b0;
        assign upper_value     = op_key;
        assign chain_in.any_le = 1'b0;
        assign chain_in.any_eq = 1'b0;
      end else begin : g_inner_high
        assign upper_valid = info[gi+1].valid;
        assign upper_value = values[gi+1];
        assign chain_in    = info[gi+1].chain;
      end

      ole_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .enable      (exec),
        .cmd         (cmd),
        .key         (op_key),
        .lower       (lower),
        .lower_value (lower_value),
        .upper_valid (upper_valid),
        .upper_value (upper_value),
        .chain_in    (chain_in),
        .self_info   (info[gi]),
        .value       (values[gi])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    found_next  = 1'b0;
    status_next = STATUS_OK;
    if (is_add) begin
      if (full) begin
        status_next = STATUS_FULL;
      end else begin
        count_next = count + CountWidth'(1);
      end
    end else if (hit) begin
      found_next = 1'b1;
      if (cmd.remove) begin
        count_next = count - CountWidth'(1);
      end
    end else begin
      status_next = STATUS_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (exec) begin
        count        <= count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      found     <= found_next;
      status    <= status_next;
      occupancy <= 5'(count_next);
    end
  end

endmodule

FILE: hw/rtl/ole_cell.sv
// One position of the ordered list: a value register, its valid flag and the compare logic.
// Depends on ole_pkg for the command, chain and neighbor types.
module ole_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       enable,
  input  ole_pkg::ole_cmd_t          cmd,
  input  logic signed [31:0]         key,
  input  ole_pkg::ole_below_t        lower,
  input  logic signed [31:0]         lower_value,
  input  logic                       upper_valid,
  input  logic signed [31:0]         upper_value,
  input  ole_pkg::ole_chain_t        chain_in,
  output ole_pkg::ole_below_t        self_info,
  output logic signed [31:0]         value
);
  import ole_pkg::*;

  logic       valid;
  logic       le;
  logic       eq;
  ole_chain_t chain_out;
  logic       take_key;
  logic       take_lower;
  logic       take_upper;

  assign le = valid && (value <= key);
  assign eq = valid && (value == key);

  assign chain_out.any_le = chain_in.any_le | le;
  assign chain_out.any_eq = chain_in.any_eq | eq;

  assign self_info.valid = valid;
  assign self_info.le    = le;
  assign self_info.chain = chain_out;

  always_comb begin
    take_key   = 1'b0;
    take_lower = 1'b0;
    take_upper = 1'b0;
    if (cmd.add && cmd.ordered) begin
      // The key lands just above the newest entry not greater than it;
      // everything above that point moves up one place.
      take_key   = lower.le && !chain_out.any_le;
      take_lower = !lower.chain.any_le;
    end else if (cmd.add) begin
      take_key = !valid && lower.valid;
    end else if (cmd.remove) begin
      // Cells from the newest match upward move down one place.
      take_upper = !chain_in.any_eq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (enable) begin
      if (cmd.add) begin
        valid <= valid | lower.valid;
      end else if (take_upper) begin
        valid <= upper_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      if (take_key) begin
        value <= key;
      end else if (take_lower) begin
        value <= lower_value;
      end else if (take_upper) begin
        value <= upper_value;
      end
    end
  end

endmodule
